/* src/quad_motor_mixer_with_spool_core_defines.svh */
// Assertion macros shared by the quad motor mixer RTL.
`ifndef QUAD_MOTOR_MIXER_WITH_SPOOL_CORE_DEFINES_SVH
`define QUAD_MOTOR_MIXER_WITH_SPOOL_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QMM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qmm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define QMM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qmm assertion failed");

`endif

/* src/qmm_pkg.sv */
// Types, constants and codes of the quad motor mixer with spool machine.
package qmm_pkg;

  localparam int FRAC_BITS  = 15;
  localparam int VAL_W      = FRAC_BITS + 1;
  localparam int DEM_W      = FRAC_BITS + 2;
  localparam int MAG_W      = FRAC_BITS + 2;
  localparam int SW         = FRAC_BITS + 5;
  localparam int TIME_W     = 24;
  localparam int DT_W       = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int MUL_W      = MAG_W;
  localparam int DIV_NUM_W  = 2 * FRAC_BITS + 2;
  localparam int DIV_DEN_W  = 24;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);

  localparam logic [VAL_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  localparam logic [15:0]       SPIN_ARM_RST     = 16'd3277;
  localparam logic [15:0]       SPIN_MIN_RST     = 16'd4915;
  localparam logic [15:0]       SPIN_MAX_RST     = 16'd31130;
  localparam logic [TIME_W-1:0] SPOOL_UP_RST     = 24'd500000;
  localparam logic [TIME_W-1:0] SPOOL_DOWN_RST   = 24'd500000;
  localparam logic [TIME_W-1:0] PILOT_TMO_RST    = 24'd2000000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPIN_ARM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIN_MIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIN_MAX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPOOL_UP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPOOL_DOWN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PILOT_TMO  = 3'd5;

  localparam logic [1:0] CMD_ARM    = 2'd1;
  localparam logic [1:0] CMD_DISARM = 2'd2;

  typedef enum logic [2:0] {
    PH_SHUT  = 3'd0,
    PH_IDLE  = 3'd1,
    PH_UP    = 3'd2,
    PH_UNLIM = 3'd3,
    PH_DOWN  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    WANT_SHUT,
    WANT_IDLE,
    WANT_UNLIM
  } want_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SPOOL,
    S_SPWAIT,
    S_FL,
    S_FL2,
    S_RP,
    S_SC1,
    S_SC1W,
    S_SC2,
    S_SC2M,
    S_SC2D,
    S_SC2W,
    S_THR,
    S_YAW,
    S_YAWW,
    S_OM1,
    S_OC1,
    S_OM2,
    S_OC2,
    S_DONE
  } seq_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

/* src/qmm_div.sv */
// Shared radix-2 restoring divider, one quotient bit per cycle.
module qmm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  qmm_pkg::div_req_t  req,
  output qmm_pkg::div_rsp_t  rsp
);

  logic [qmm_pkg::DIV_NUM_W-1:0] num_r;
  logic [qmm_pkg::DIV_DEN_W-1:0] den_r;
  logic [qmm_pkg::DIV_DEN_W-1:0] rem_r;
  logic [qmm_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic [qmm_pkg::DIV_DEN_W:0]   rem_sh;
  logic                          ge;

  assign rem_sh = {rem_r, num_r[qmm_pkg::DIV_NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= qmm_pkg::DIV_CNT_W'(qmm_pkg::DIV_NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == qmm_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The numerator register shifts out dividend bits and shifts in quotient bits.
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[qmm_pkg::DIV_NUM_W-2:0], ge};
      rem_r <= ge ? qmm_pkg::DIV_DEN_W'(rem_sh - {1'b0, den_r})
                  : rem_sh[qmm_pkg::DIV_DEN_W-1:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = num_r;

endmodule

/* src/quad_motor_mixer_with_spool_core.sv */
// Top level: quad X motor mixer with spool machine, run by a sequencer over one divider.
// A shut down or ground idle tick skips the mix; each division in the shared 32-step
// divider holds the sequencer until it is done, up to nine divisions per tick.
// A new request is taken only in the idle state, after the last result has entered the
// result register; result stalls hold the sequencer until that register is free.
// Reset is synchronous and active low; it restores register defaults and shut down.
`include "quad_motor_mixer_with_spool_core_defines.svh"

module quad_motor_mixer_with_spool_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [qmm_pkg::DEM_W-1:0]     in_roll_demand,
  input  logic signed [qmm_pkg::DEM_W-1:0]     in_pitch_demand,
  input  logic signed [qmm_pkg::DEM_W-1:0]     in_yaw_demand,
  input  logic [15:0]                          in_throttle_demand,
  input  logic [qmm_pkg::DT_W-1:0]             in_elapsed_us,
  input  logic [1:0]                           in_arm_command,
  input  logic                                 in_pilot_active,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [15:0]                          out_thrust_front_right,
  output logic [15:0]                          out_thrust_rear_left,
  output logic [15:0]                          out_thrust_front_left,
  output logic [15:0]                          out_thrust_rear_right,
  output logic [2:0]                           out_spool_phase,
  output logic                                 out_limit_roll_pitch,
  output logic                                 out_limit_throttle_upper,
  output logic                                 out_limit_throttle_lower,
  output logic                                 out_limit_yaw,
  input  logic                                 cfg_we,
  input  logic [qmm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [qmm_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int VW = qmm_pkg::VAL_W;
  localparam int MW = qmm_pkg::MAG_W;
  localparam int SW = qmm_pkg::SW;
  localparam int FB = qmm_pkg::FRAC_BITS;
  localparam int TW = qmm_pkg::TIME_W;
  localparam int NW = qmm_pkg::DIV_NUM_W;
  localparam int DW = qmm_pkg::DIV_DEN_W;
  localparam int UW = qmm_pkg::MUL_W;

  // Configuration registers.
  logic [VW-1:0] arm_lvl_r, min_lvl_r, max_lvl_r;
  logic [VW-1:0] arm_lvl_nxt, min_lvl_nxt, max_lvl_nxt;
  logic [TW-1:0] up_time_r, down_time_r, timeout_r;
  logic [TW-1:0] up_time_nxt, down_time_nxt, timeout_nxt;

  // Block state.
  logic              armed_r, armed_nxt;
  qmm_pkg::phase_t   phase_r, phase_nxt;
  logic [VW-1:0]     ratio_r, ratio_nxt;
  logic [TW-1:0]     idle_r, idle_nxt;
  qmm_pkg::seq_t     seq_r, seq_nxt;
  logic [1:0]        k_r, k_nxt;

  // Latched request.
  logic signed [qmm_pkg::DEM_W-1:0] roll_r, roll_nxt, pitch_r, pitch_nxt;
  logic [VW-1:0]                    ym_r, ym_nxt, thr_r, thr_nxt;
  logic                             yneg_r, yneg_nxt;
  logic [qmm_pkg::DT_W-1:0]         dt_r, dt_nxt;
  logic [1:0]                       cmd_r, cmd_nxt;
  logic                             pa_r, pa_nxt;

  // Mixer work registers.
  logic [MW-1:0]   mag_r [2];
  logic [MW-1:0]   mag_nxt [2];
  logic [1:0]      sgn_r, sgn_nxt;
  logic [MW:0]     span_r, span_nxt;
  logic [MW-1:0]   d_r, d_nxt;
  logic [VW-1:0]   tmax_r, tmax_nxt, fl_r, fl_nxt, ys_r, ys_nxt, mo_r, mo_nxt;
  logic [MW-1:0]   t_r, t_nxt;
  logic [VW-1:0]   thw_r [4];
  logic [VW-1:0]   thw_nxt [4];
  logic [3:0]      flg_r, flg_nxt;
  logic [2*UW-1:0] mul_p_r;
  logic [UW-1:0]   mul_a, mul_b;

  // Result register.
  logic            out_valid_r, out_valid_nxt;
  logic [VW-1:0]   o_th_r [4];
  logic [VW-1:0]   o_th_nxt [4];
  logic [2:0]      o_ph_r, o_ph_nxt;
  logic [3:0]      o_flg_r, o_flg_nxt;

  qmm_pkg::div_req_t div_req;
  qmm_pkg::div_rsp_t div_rsp;

  qmm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  function automatic logic signed [qmm_pkg::DEM_W-1:0] clamp_dem(
    input logic signed [qmm_pkg::DEM_W-1:0] v
  );
    logic signed [qmm_pkg::DEM_W-1:0] lim;
    lim = $signed({1'b0, qmm_pkg::ONE});
    if (v > lim) return lim;
    else if (v < -lim) return -lim;
    else return v;
  endfunction

  // Effective spin limits, put in order.
  logic [VW-1:0] arm_e, min_c, min_e, max_c, max_e;
  assign arm_e = (arm_lvl_r > qmm_pkg::ONE) ? qmm_pkg::ONE : arm_lvl_r;
  assign min_c = (min_lvl_r > qmm_pkg::ONE) ? qmm_pkg::ONE : min_lvl_r;
  assign min_e = (min_c < arm_e) ? arm_e : min_c;
  assign max_c = (max_lvl_r > qmm_pkg::ONE) ? qmm_pkg::ONE : max_lvl_r;
  assign max_e = (max_c < min_e) ? min_e : max_c;

  // Per-motor terms for motor k: rp alternates sign within each pair, yaw by pair.
  logic [MW-1:0]        h_c;
  logic                 rpneg_c, ysg_c;
  logic signed [SW-1:0] rp_c, base_c, room_c, one_s, need_s;
  assign h_c     = (mag_r[0] > mag_r[1]) ? mag_r[0] : mag_r[1];
  assign rpneg_c = sgn_r[k_r[1]] ^ k_r[0];
  assign ysg_c   = yneg_r ^ k_r[1];
  assign one_s   = $signed({{(SW-VW){1'b0}}, qmm_pkg::ONE});
  assign need_s  = $signed({{(SW-VW){1'b0}}, ym_r});
  assign rp_c    = rpneg_c ? -$signed({{(SW-MW){1'b0}}, mag_r[k_r[1]]})
                           :  $signed({{(SW-MW){1'b0}}, mag_r[k_r[1]]});
  assign base_c  = $signed({{(SW-MW){1'b0}}, t_r}) + rp_c;
  assign room_c  = ysg_c ? base_c : (one_s - base_c);

  always_comb begin
    logic signed [qmm_pkg::DEM_W-1:0] yc, yneg_v;
    logic [TW-1:0]     idle_a;
    logic [TW:0]       isum;
    logic              armed_a;
    qmm_pkg::want_t    want;
    qmm_pkg::phase_t   ph1;
    logic [VW-1:0]     ratio1;
    logic [NW:0]       usum;
    logic signed [MW:0] a_c, b_c, na_c, nb_c;
    logic [MW-1:0]     am, bm, hh, t0, t1, ohm;
    logic signed [SW-1:0] yt_s, mo_s;

    arm_lvl_nxt   = arm_lvl_r;
    min_lvl_nxt   = min_lvl_r;
    max_lvl_nxt   = max_lvl_r;
    up_time_nxt   = up_time_r;
    down_time_nxt = down_time_r;
    timeout_nxt   = timeout_r;
    armed_nxt     = armed_r;
    phase_nxt     = phase_r;
    ratio_nxt     = ratio_r;
    idle_nxt      = idle_r;
    seq_nxt       = seq_r;
    k_nxt         = k_r;
    roll_nxt      = roll_r;
    pitch_nxt     = pitch_r;
    ym_nxt        = ym_r;
    yneg_nxt      = yneg_r;
    thr_nxt       = thr_r;
    dt_nxt        = dt_r;
    cmd_nxt       = cmd_r;
    pa_nxt        = pa_r;
    mag_nxt       = mag_r;
    sgn_nxt       = sgn_r;
    span_nxt      = span_r;
    d_nxt         = d_r;
    tmax_nxt      = tmax_r;
    fl_nxt        = fl_r;
    ys_nxt        = ys_r;
    mo_nxt        = mo_r;
    t_nxt         = t_r;
    thw_nxt       = thw_r;
    flg_nxt       = flg_r;
    o_th_nxt      = o_th_r;
    o_ph_nxt      = o_ph_r;
    o_flg_nxt     = o_flg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_req       = '0;

    yc     = clamp_dem(in_yaw_demand);
    yneg_v = -yc;

    // Tick prologue: arm command, pilot activity and the idle timer.
    idle_a  = (cmd_r == qmm_pkg::CMD_ARM) ? timeout_r : idle_r;
    if (pa_r) idle_a = '0;
    isum = {1'b0, idle_a} + {{(TW + 1 - qmm_pkg::DT_W){1'b0}}, dt_r};
    if (dt_r != '0 && idle_a < timeout_r)
      idle_a = (isum > {1'b0, timeout_r}) ? timeout_r : isum[TW-1:0];
    armed_a = (cmd_r == qmm_pkg::CMD_ARM) ? 1'b1 :
              (cmd_r == qmm_pkg::CMD_DISARM) ? 1'b0 : armed_r;
    if (!armed_a) want = qmm_pkg::WANT_SHUT;
    else if (idle_a >= timeout_r) want = qmm_pkg::WANT_IDLE;
    else want = qmm_pkg::WANT_UNLIM;
    ph1    = (cmd_r == qmm_pkg::CMD_DISARM) ? qmm_pkg::PH_SHUT : phase_r;
    ratio1 = (cmd_r == qmm_pkg::CMD_DISARM) ? '0 : ratio_r;

    usum = {{(NW + 1 - VW){1'b0}}, ratio_r} + {1'b0, div_rsp.quo};

    a_c  = $signed({pitch_r[qmm_pkg::DEM_W-1], pitch_r})
         - $signed({roll_r[qmm_pkg::DEM_W-1], roll_r});
    b_c  = $signed({pitch_r[qmm_pkg::DEM_W-1], pitch_r})
         + $signed({roll_r[qmm_pkg::DEM_W-1], roll_r});
    na_c = -a_c;
    nb_c = -b_c;
    am   = a_c[MW] ? na_c[MW-1:0] : a_c[MW-1:0];
    bm   = b_c[MW] ? nb_c[MW-1:0] : b_c[MW-1:0];
    hh   = (am > bm) ? am : bm;

    t0  = (thr_r > tmax_r) ? {1'b0, tmax_r} : {1'b0, thr_r};
    t1  = (t0 < h_c) ? h_c : t0;
    ohm = {1'b0, qmm_pkg::ONE} - h_c;

    yt_s = $signed({{(SW-MW){1'b0}}, mul_p_r[FB +: MW]});
    mo_s = $signed({{(SW-MW){1'b0}}, t_r}) + rp_c + (ysg_c ? -yt_s : yt_s);

    unique case (seq_r)
      qmm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          roll_nxt  = clamp_dem(in_roll_demand);
          pitch_nxt = clamp_dem(in_pitch_demand);
          yneg_nxt  = yc[qmm_pkg::DEM_W-1];
          ym_nxt    = yc[qmm_pkg::DEM_W-1] ? yneg_v[VW-1:0] : yc[VW-1:0];
          thr_nxt   = (in_throttle_demand > qmm_pkg::ONE) ? qmm_pkg::ONE
                                                          : in_throttle_demand;
          dt_nxt    = in_elapsed_us;
          cmd_nxt   = in_arm_command;
          pa_nxt    = in_pilot_active;
          seq_nxt   = qmm_pkg::S_SPOOL;
        end
      end
      qmm_pkg::S_SPOOL: begin
        armed_nxt = armed_a;
        idle_nxt  = idle_a;
        phase_nxt = ph1;
        ratio_nxt = ratio1;
        seq_nxt   = qmm_pkg::S_FL;
        unique case (ph1)
          qmm_pkg::PH_SHUT: begin
            ratio_nxt = '0;
            if (want != qmm_pkg::WANT_SHUT) phase_nxt = qmm_pkg::PH_IDLE;
          end
          qmm_pkg::PH_IDLE: begin
            ratio_nxt = '0;
            if (want == qmm_pkg::WANT_SHUT) phase_nxt = qmm_pkg::PH_SHUT;
            else if (want == qmm_pkg::WANT_UNLIM) phase_nxt = qmm_pkg::PH_UP;
          end
          qmm_pkg::PH_UP: begin
            if (want != qmm_pkg::WANT_UNLIM) begin
              phase_nxt = qmm_pkg::PH_DOWN;
            end else if (up_time_r != '0) begin
              div_req.start = 1'b1;
              div_req.num   = NW'({dt_r, {FB{1'b0}}});
              div_req.den   = DW'(up_time_r);
              seq_nxt       = qmm_pkg::S_SPWAIT;
            end else begin
              ratio_nxt = qmm_pkg::ONE;
              phase_nxt = qmm_pkg::PH_UNLIM;
            end
          end
          qmm_pkg::PH_UNLIM: begin
            ratio_nxt = qmm_pkg::ONE;
            if (want != qmm_pkg::WANT_UNLIM) phase_nxt = qmm_pkg::PH_DOWN;
          end
          default: begin
            if (want == qmm_pkg::WANT_UNLIM) begin
              phase_nxt = qmm_pkg::PH_UP;
            end else if (down_time_r != '0) begin
              div_req.start = 1'b1;
              div_req.num   = NW'({dt_r, {FB{1'b0}}});
              div_req.den   = DW'(down_time_r);
              seq_nxt       = qmm_pkg::S_SPWAIT;
            end else begin
              ratio_nxt = '0;
              phase_nxt = qmm_pkg::PH_IDLE;
            end
          end
        endcase
      end
      qmm_pkg::S_SPWAIT: begin
        if (div_rsp.done) begin
          seq_nxt = qmm_pkg::S_FL;
          if (phase_r == qmm_pkg::PH_UP) begin
            if (usum >= {{(NW + 1 - VW){1'b0}}, qmm_pkg::ONE}) begin
              ratio_nxt = qmm_pkg::ONE;
              phase_nxt = qmm_pkg::PH_UNLIM;
            end else begin
              ratio_nxt = usum[VW-1:0];
            end
          end else begin
            if (div_rsp.quo >= {{(NW - VW){1'b0}}, ratio_r}) begin
              ratio_nxt = '0;
              phase_nxt = qmm_pkg::PH_IDLE;
            end else begin
              ratio_nxt = ratio_r - div_rsp.quo[VW-1:0];
            end
          end
        end
      end
      qmm_pkg::S_FL: begin
        flg_nxt = '0;
        unique case (phase_r)
          qmm_pkg::PH_SHUT: begin
            for (int i = 0; i < 4; i++) thw_nxt[i] = '0;
            seq_nxt = qmm_pkg::S_DONE;
          end
          qmm_pkg::PH_IDLE: begin
            for (int i = 0; i < 4; i++) thw_nxt[i] = arm_e;
            seq_nxt = qmm_pkg::S_DONE;
          end
          qmm_pkg::PH_UNLIM: begin
            fl_nxt   = min_e;
            tmax_nxt = qmm_pkg::ONE;
            seq_nxt  = qmm_pkg::S_RP;
          end
          default: begin
            mul_a   = UW'(min_e - arm_e);
            mul_b   = UW'(ratio_r);
            seq_nxt = qmm_pkg::S_FL2;
          end
        endcase
      end
      qmm_pkg::S_FL2: begin
        fl_nxt   = arm_e + mul_p_r[FB +: VW];
        tmax_nxt = ratio_r;
        seq_nxt  = qmm_pkg::S_RP;
      end
      qmm_pkg::S_RP: begin
        mag_nxt[0] = am;
        mag_nxt[1] = bm;
        sgn_nxt    = {b_c[MW], a_c[MW]};
        span_nxt   = {hh, 1'b0};
        k_nxt      = '0;
        if ({hh, 1'b0} > {2'b0, qmm_pkg::ONE}) begin
          flg_nxt[0] = 1'b1;
          seq_nxt    = qmm_pkg::S_SC1;
        end else begin
          seq_nxt = qmm_pkg::S_SC2;
        end
      end
      qmm_pkg::S_SC1: begin
        div_req.start = 1'b1;
        div_req.num   = NW'({mag_r[k_r[0]], {FB{1'b0}}});
        div_req.den   = DW'(span_r);
        seq_nxt       = qmm_pkg::S_SC1W;
      end
      qmm_pkg::S_SC1W: begin
        if (div_rsp.done) begin
          mag_nxt[k_r[0]] = div_rsp.quo[MW-1:0];
          if (k_r[0]) begin
            k_nxt   = '0;
            seq_nxt = qmm_pkg::S_SC2;
          end else begin
            k_nxt   = 2'd1;
            seq_nxt = qmm_pkg::S_SC1;
          end
        end
      end
      qmm_pkg::S_SC2: begin
        k_nxt = '0;
        if (h_c > {1'b0, tmax_r}) begin
          flg_nxt[0] = 1'b1;
          d_nxt      = h_c;
          seq_nxt    = qmm_pkg::S_SC2M;
        end else begin
          seq_nxt = qmm_pkg::S_THR;
        end
      end
      qmm_pkg::S_SC2M: begin
        mul_a   = mag_r[k_r[0]];
        mul_b   = UW'(tmax_r);
        seq_nxt = qmm_pkg::S_SC2D;
      end
      qmm_pkg::S_SC2D: begin
        div_req.start = 1'b1;
        div_req.num   = mul_p_r[NW-1:0];
        div_req.den   = DW'(d_r);
        seq_nxt       = qmm_pkg::S_SC2W;
      end
      qmm_pkg::S_SC2W: begin
        if (div_rsp.done) begin
          mag_nxt[k_r[0]] = div_rsp.quo[MW-1:0];
          if (k_r[0]) begin
            k_nxt   = '0;
            seq_nxt = qmm_pkg::S_THR;
          end else begin
            k_nxt   = 2'd1;
            seq_nxt = qmm_pkg::S_SC2M;
          end
        end
      end
      qmm_pkg::S_THR: begin
        // Collective: cap at the ramp limit, lift off the floor, then keep headroom.
        if (thr_r > tmax_r) flg_nxt[1] = 1'b1;
        if (t0 < h_c) flg_nxt[2] = 1'b1;
        if (t1 > ohm) begin
          t_nxt      = ohm;
          flg_nxt[1] = 1'b1;
        end else begin
          t_nxt = t1;
        end
        ys_nxt  = qmm_pkg::ONE;
        k_nxt   = '0;
        seq_nxt = qmm_pkg::S_YAW;
      end
      qmm_pkg::S_YAW: begin
        k_nxt   = k_r + 1'b1;
        seq_nxt = (k_r == 2'd3) ? qmm_pkg::S_OM1 : qmm_pkg::S_YAW;
        if (need_s > room_c) begin
          if (room_c <= 0) begin
            ys_nxt = '0;
          end else begin
            div_req.start = 1'b1;
            div_req.num   = NW'({room_c[VW-1:0], {FB{1'b0}}});
            div_req.den   = DW'(ym_r);
            k_nxt         = k_r;
            seq_nxt       = qmm_pkg::S_YAWW;
          end
        end
      end
      qmm_pkg::S_YAWW: begin
        if (div_rsp.done) begin
          if (div_rsp.quo < {{(NW - VW){1'b0}}, ys_r}) ys_nxt = div_rsp.quo[VW-1:0];
          k_nxt   = k_r + 1'b1;
          seq_nxt = (k_r == 2'd3) ? qmm_pkg::S_OM1 : qmm_pkg::S_YAW;
        end
      end
      qmm_pkg::S_OM1: begin
        mul_a   = UW'(ys_r);
        mul_b   = UW'(ym_r);
        seq_nxt = qmm_pkg::S_OC1;
      end
      qmm_pkg::S_OC1: begin
        if (mo_s < 0) mo_nxt = '0;
        else if (mo_s > one_s) mo_nxt = qmm_pkg::ONE;
        else mo_nxt = mo_s[VW-1:0];
        seq_nxt = qmm_pkg::S_OM2;
      end
      qmm_pkg::S_OM2: begin
        mul_a   = UW'(mo_r);
        mul_b   = UW'(max_e - fl_r);
        seq_nxt = qmm_pkg::S_OC2;
      end
      qmm_pkg::S_OC2: begin
        thw_nxt[k_r] = fl_r + mul_p_r[FB +: VW];
        flg_nxt[3]   = ys_r < qmm_pkg::ONE;
        k_nxt        = k_r + 1'b1;
        seq_nxt      = (k_r == 2'd3) ? qmm_pkg::S_DONE : qmm_pkg::S_OM1;
      end
      qmm_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          o_th_nxt      = thw_r;
          o_ph_nxt      = phase_r;
          o_flg_nxt     = flg_r;
          out_valid_nxt = 1'b1;
          seq_nxt       = qmm_pkg::S_IDLE;
        end
      end
      default: seq_nxt = qmm_pkg::S_IDLE;
    endcase

    // Configuration writes must arrive only while the sequencer is idle; the block does not enforce it.
    if (cfg_we) begin
      unique case (cfg_index)
        qmm_pkg::CFG_SPIN_ARM:   arm_lvl_nxt   = cfg_wdata[VW-1:0];
        qmm_pkg::CFG_SPIN_MIN:   min_lvl_nxt   = cfg_wdata[VW-1:0];
        qmm_pkg::CFG_SPIN_MAX:   max_lvl_nxt   = cfg_wdata[VW-1:0];
        qmm_pkg::CFG_SPOOL_UP:   up_time_nxt   = cfg_wdata[TW-1:0];
        qmm_pkg::CFG_SPOOL_DOWN: down_time_nxt = cfg_wdata[TW-1:0];
        qmm_pkg::CFG_PILOT_TMO: begin
          timeout_nxt = cfg_wdata[TW-1:0];
          if (idle_r > cfg_wdata[TW-1:0]) idle_nxt = cfg_wdata[TW-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_lvl_r   <= qmm_pkg::SPIN_ARM_RST;
      min_lvl_r   <= qmm_pkg::SPIN_MIN_RST;
      max_lvl_r   <= qmm_pkg::SPIN_MAX_RST;
      up_time_r   <= qmm_pkg::SPOOL_UP_RST;
      down_time_r <= qmm_pkg::SPOOL_DOWN_RST;
      timeout_r   <= qmm_pkg::PILOT_TMO_RST;
      armed_r     <= 1'b0;
      phase_r     <= qmm_pkg::PH_SHUT;
      ratio_r     <= '0;
      idle_r      <= qmm_pkg::PILOT_TMO_RST;
      seq_r       <= qmm_pkg::S_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      arm_lvl_r   <= arm_lvl_nxt;
      min_lvl_r   <= min_lvl_nxt;
      max_lvl_r   <= max_lvl_nxt;
      up_time_r   <= up_time_nxt;
      down_time_r <= down_time_nxt;
      timeout_r   <= timeout_nxt;
      armed_r     <= armed_nxt;
      phase_r     <= phase_nxt;
      ratio_r     <= ratio_nxt;
      idle_r      <= idle_nxt;
      seq_r       <= seq_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    roll_r  <= roll_nxt;
    pitch_r <= pitch_nxt;
    ym_r    <= ym_nxt;
    yneg_r  <= yneg_nxt;
    thr_r   <= thr_nxt;
    dt_r    <= dt_nxt;
    cmd_r   <= cmd_nxt;
    pa_r    <= pa_nxt;
    mag_r   <= mag_nxt;
    sgn_r   <= sgn_nxt;
    span_r  <= span_nxt;
    d_r     <= d_nxt;
    tmax_r  <= tmax_nxt;
    fl_r    <= fl_nxt;
    ys_r    <= ys_nxt;
    mo_r    <= mo_nxt;
    t_r     <= t_nxt;
    thw_r   <= thw_nxt;
    flg_r   <= flg_nxt;
    o_th_r  <= o_th_nxt;
    o_ph_r  <= o_ph_nxt;
    o_flg_r <= o_flg_nxt;
    mul_p_r <= mul_a * mul_b;
  end

  assign out_valid                = out_valid_r;
  assign out_thrust_front_right   = o_th_r[0];
  assign out_thrust_rear_left     = o_th_r[1];
  assign out_thrust_front_left    = o_th_r[2];
  assign out_thrust_rear_right    = o_th_r[3];
  assign out_spool_phase          = o_ph_r;
  assign out_limit_roll_pitch     = o_flg_r[0];
  assign out_limit_throttle_upper = o_flg_r[1];
  assign out_limit_throttle_lower = o_flg_r[2];
  assign out_limit_yaw            = o_flg_r[3];

  `QMM_ASSERT_IMP(a_ratio_range, clk, rst_n, 1'b1, ratio_r <= qmm_pkg::ONE)
  `QMM_ASSERT_IMP(a_shut_zero, clk, rst_n, out_valid_r && o_ph_r == qmm_pkg::PH_SHUT, o_th_r[0] == '0 && o_th_r[3] == '0 && o_flg_r == '0)
  `QMM_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `QMM_ASSERT_IMP(a_div_idle_quiet, clk, rst_n, seq_r == qmm_pkg::S_IDLE, !div_req.start)

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the quad X motor mixer with spool machine.
`timescale 1ns / 100ps

module testbench;

  localparam longint UNIT = 32768;
  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 400;
  localparam longint ROLL_SIGN[4]  = '{-1, 1, 1, -1};
  localparam longint PITCH_SIGN[4] = '{1, -1, 1, -1};
  localparam longint YAW_SIGN[4]   = '{1, 1, -1, -1};

  typedef struct packed {
    logic [3:0][15:0] thrust;
    logic [2:0]       phase;
    logic [3:0]       lim;
  } motor_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [qmm_pkg::DEM_W-1:0] in_roll_demand = '0;
  logic signed [qmm_pkg::DEM_W-1:0] in_pitch_demand = '0;
  logic signed [qmm_pkg::DEM_W-1:0] in_yaw_demand = '0;
  logic [15:0] in_throttle_demand = '0;
  logic [qmm_pkg::DT_W-1:0] in_elapsed_us = '0;
  logic [1:0] in_arm_command = '0;
  logic in_pilot_active = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_thrust_front_right, out_thrust_rear_left;
  logic [15:0] out_thrust_front_left, out_thrust_rear_right;
  logic [2:0] out_spool_phase;
  logic out_limit_roll_pitch, out_limit_throttle_upper;
  logic out_limit_throttle_lower, out_limit_yaw;
  logic cfg_we = 1'b0;
  logic [qmm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [qmm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predicted block state and register copies.
  logic   armed;
  qmm_pkg::phase_t phase;
  longint ramp, idle_us;
  longint arm_lvl, min_lvl, max_lvl, up_us, down_us, tmo_us;

  motor_cmd_t pending_cmds[$];
  int errors = 0;
  int ticks_sent = 0;
  int results_seen = 0;
  int in_gap_pct = 0;
  int out_stall_pct = 0;

  quad_motor_mixer_with_spool_core uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) out_ready <= ($urandom_range(99) >= out_stall_pct);

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void mix_quad(input longint roll, pitch, yaw, thr, tmax, fl, smax,
                                   output longint th[4], output logic [3:0] lim);
    longint rp[4];
    longint lo, hi, t, ys, span, d, y, base, room, need, s, o;
    lim = '0;
    ys = UNIT;
    for (int i = 0; i < 4; i++) rp[i] = roll * ROLL_SIGN[i] + pitch * PITCH_SIGN[i];
    lo = rp[0];
    hi = rp[0];
    for (int i = 1; i < 4; i++) begin
      if (rp[i] < lo) lo = rp[i];
      if (rp[i] > hi) hi = rp[i];
    end
    if (hi - lo > UNIT) begin
      span = hi - lo;
      for (int i = 0; i < 4; i++) rp[i] = rp[i] * UNIT / span;
      lo = lo * UNIT / span;
      hi = hi * UNIT / span;
      lim[0] = 1'b1;
    end
    if (lo < -tmax) begin
      d = -lo;
      for (int i = 0; i < 4; i++) rp[i] = rp[i] * tmax / d;
      lo = lo * tmax / d;
      hi = hi * tmax / d;
      lim[0] = 1'b1;
    end
    t = thr;
    if (t > tmax) begin t = tmax; lim[1] = 1'b1; end
    if (t < -lo) begin t = -lo; lim[2] = 1'b1; end
    if (t > UNIT - hi) begin t = UNIT - hi; lim[1] = 1'b1; end
    // Yaw gets only the headroom left after roll, pitch and collective.
    for (int i = 0; i < 4; i++) begin
      y = yaw * YAW_SIGN[i];
      base = t + rp[i];
      room = (y >= 0) ? (UNIT - base) : base;
      need = (y < 0) ? -y : y;
      if (need > room) begin
        s = (room <= 0) ? 0 : room * UNIT / need;
        if (s < ys) ys = s;
      end
    end
    if (ys < UNIT) begin
      if (ys < 0) ys = 0;
      lim[3] = 1'b1;
    end
    for (int i = 0; i < 4; i++) begin
      o = clip(t + rp[i] + ys * (yaw * YAW_SIGN[i]) / UNIT, 0, UNIT);
      th[i] = fl + o * (smax - fl) / UNIT;
    end
  endfunction

  function automatic motor_cmd_t predict_tick(input logic signed [qmm_pkg::DEM_W-1:0] r, p, y,
                                              input logic [15:0] thr, input logic [15:0] dt,
                                              input logic [1:0] cmd, input logic pil);
    motor_cmd_t res;
    longint th[4];
    logic [3:0] lim;
    longint a_e, m_e, x_e, fl;
    qmm_pkg::want_t want;
    res = '0;
    lim = '0;
    for (int i = 0; i < 4; i++) th[i] = 0;
    if (cmd == qmm_pkg::CMD_ARM) begin
      idle_us = tmo_us;
      armed = 1'b1;
    end else if (cmd == qmm_pkg::CMD_DISARM) begin
      armed = 1'b0;
      phase = qmm_pkg::PH_SHUT;
      ramp = 0;
    end
    if (pil) idle_us = 0;
    if (dt > 0 && idle_us < tmo_us) idle_us = clip(idle_us + dt, 0, tmo_us);
    if (!armed) want = qmm_pkg::WANT_SHUT;
    else if (idle_us >= tmo_us) want = qmm_pkg::WANT_IDLE;
    else want = qmm_pkg::WANT_UNLIM;
    case (phase)
      qmm_pkg::PH_SHUT: begin
        ramp = 0;
        if (want != qmm_pkg::WANT_SHUT) phase = qmm_pkg::PH_IDLE;
      end
      qmm_pkg::PH_IDLE: begin
        ramp = 0;
        if (want == qmm_pkg::WANT_SHUT) phase = qmm_pkg::PH_SHUT;
        else if (want == qmm_pkg::WANT_UNLIM) phase = qmm_pkg::PH_UP;
      end
      qmm_pkg::PH_UP: begin
        if (want != qmm_pkg::WANT_UNLIM) phase = qmm_pkg::PH_DOWN;
        else begin
          if (up_us > 0) ramp += longint'(dt) * UNIT / up_us;
          else ramp = UNIT;
          if (ramp >= UNIT) begin ramp = UNIT; phase = qmm_pkg::PH_UNLIM; end
        end
      end
      qmm_pkg::PH_UNLIM: begin
        ramp = UNIT;
        if (want != qmm_pkg::WANT_UNLIM) phase = qmm_pkg::PH_DOWN;
      end
      default: begin
        if (want == qmm_pkg::WANT_UNLIM) phase = qmm_pkg::PH_UP;
        else begin
          if (down_us > 0) ramp -= longint'(dt) * UNIT / down_us;
          else ramp = 0;
          if (ramp <= 0) begin ramp = 0; phase = qmm_pkg::PH_IDLE; end
        end
      end
    endcase
    a_e = clip(arm_lvl, 0, UNIT);
    m_e = clip(min_lvl, 0, UNIT);
    if (m_e < a_e) m_e = a_e;
    x_e = clip(max_lvl, 0, UNIT);
    if (x_e < m_e) x_e = m_e;
    if (phase == qmm_pkg::PH_IDLE) begin
      for (int i = 0; i < 4; i++) th[i] = a_e;
    end else if (phase == qmm_pkg::PH_UP || phase == qmm_pkg::PH_DOWN) begin
      fl = a_e + (m_e - a_e) * ramp / UNIT;
      mix_quad(clip(r, -UNIT, UNIT), clip(p, -UNIT, UNIT), clip(y, -UNIT, UNIT),
               clip(thr, 0, UNIT), ramp, fl, x_e, th, lim);
    end else if (phase == qmm_pkg::PH_UNLIM) begin
      mix_quad(clip(r, -UNIT, UNIT), clip(p, -UNIT, UNIT), clip(y, -UNIT, UNIT),
               clip(thr, 0, UNIT), UNIT, m_e, x_e, th, lim);
    end
    for (int i = 0; i < 4; i++) res.thrust[i] = th[i][15:0];
    res.phase = phase;
    res.lim = lim;
    return res;
  endfunction

  task automatic reset_prediction();
    armed = 1'b0;
    phase = qmm_pkg::PH_SHUT;
    ramp = 0;
    arm_lvl = qmm_pkg::SPIN_ARM_RST;
    min_lvl = qmm_pkg::SPIN_MIN_RST;
    max_lvl = qmm_pkg::SPIN_MAX_RST;
    up_us = qmm_pkg::SPOOL_UP_RST;
    down_us = qmm_pkg::SPOOL_DOWN_RST;
    tmo_us = qmm_pkg::PILOT_TMO_RST;
    idle_us = tmo_us;
  endtask

  // The caller lowers cfg_we once a batch is done, as set_regs does.
  task automatic write_reg(input logic [qmm_pkg::CFG_IDX_W-1:0] idx, input longint val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[qmm_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    case (idx)
      qmm_pkg::CFG_SPIN_ARM:   arm_lvl = val & 16'hFFFF;
      qmm_pkg::CFG_SPIN_MIN:   min_lvl = val & 16'hFFFF;
      qmm_pkg::CFG_SPIN_MAX:   max_lvl = val & 16'hFFFF;
      qmm_pkg::CFG_SPOOL_UP:   up_us = val & 24'hFFFFFF;
      qmm_pkg::CFG_SPOOL_DOWN: down_us = val & 24'hFFFFFF;
      qmm_pkg::CFG_PILOT_TMO: begin
        tmo_us = val & 24'hFFFFFF;
        if (idle_us > tmo_us) idle_us = tmo_us;
      end
      default: ;
    endcase
  endtask

  task automatic set_regs(input longint a, mn, mx, up, dn, tmo);
    write_reg(qmm_pkg::CFG_SPIN_ARM, a);
    write_reg(qmm_pkg::CFG_SPIN_MIN, mn);
    write_reg(qmm_pkg::CFG_SPIN_MAX, mx);
    write_reg(qmm_pkg::CFG_SPOOL_UP, up);
    write_reg(qmm_pkg::CFG_SPOOL_DOWN, dn);
    write_reg(qmm_pkg::CFG_PILOT_TMO, tmo);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_tick(input logic signed [qmm_pkg::DEM_W-1:0] r, p, y,
                           input logic [15:0] thr,
                           input logic [15:0] dt, input logic [1:0] cmd, input logic pil);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_roll_demand <= r;
    in_pitch_demand <= p;
    in_yaw_demand <= y;
    in_throttle_demand <= thr;
    in_elapsed_us <= dt;
    in_arm_command <= cmd;
    in_pilot_active <= pil;
    do @(posedge clk); while (!in_ready);
    pending_cmds.push_back(predict_tick(r, p, y, thr, dt, cmd, pil));
    ticks_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [qmm_pkg::DEM_W-1:0] rand_demand();
    int sel;
    sel = $urandom_range(19);
    if (sel == 0) return 17'sd32768;
    if (sel == 1) return -17'sd32768;
    if (sel < 4) return qmm_pkg::DEM_W'($urandom);  // raw bits, out of range values get clamped
    return qmm_pkg::DEM_W'($urandom_range(65536) - 32768);
  endfunction

  function automatic logic [15:0] rand_throttle();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return 16'($urandom);
    if (sel == 1) return 16'd32768;
    return 16'($urandom_range(32768));
  endfunction

  task automatic fly_random(input int count, input int active_pct, input int max_dt);
    logic [1:0] cmd;
    logic [15:0] dt;
    int sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (!armed && sel < 30) cmd = qmm_pkg::CMD_ARM;
      else if (sel == 99) cmd = qmm_pkg::CMD_DISARM;
      else if (sel == 98) cmd = qmm_pkg::CMD_ARM;
      else if (sel == 97) cmd = CMD_UNUSED;
      else cmd = CMD_NONE;
      sel = $urandom_range(99);
      if (sel < 5) dt = '0;
      else if (sel < 10) dt = 16'($urandom);
      else dt = 16'($urandom_range(max_dt, 1));
      send_tick(rand_demand(), rand_demand(), rand_demand(), rand_throttle(), dt, cmd,
                $urandom_range(99) < active_pct);
    end
  endtask

  task automatic test_directed_extremes();
    set_regs(qmm_pkg::SPIN_ARM_RST, qmm_pkg::SPIN_MIN_RST, qmm_pkg::SPIN_MAX_RST, 0, 0,
             qmm_pkg::PILOT_TMO_RST);
    send_tick(0, 0, 0, 0, 1000, CMD_NONE, 1'b0);
    send_tick(0, 0, 0, 0, 1000, CMD_UNUSED, 1'b1);
    send_tick(0, 0, 0, 16'd16384, 0, qmm_pkg::CMD_ARM, 1'b0);
    send_tick(0, 0, 0, 16'd16384, 1000, CMD_NONE, 1'b1);
    send_tick(0, 0, 0, 16'd16384, 1000, CMD_NONE, 1'b1);
    send_tick(17'sd32768, 17'sd32768, 17'sd32768, 16'd32768, 1000, CMD_NONE, 1'b1);
    send_tick(-17'sd32768, -17'sd32768, -17'sd32768, 16'd0, 1000, CMD_NONE, 1'b1);
    send_tick(17'sd32768, -17'sd32768, 17'sd32768, 16'd30000, 1000, CMD_NONE, 1'b1);
    send_tick(17'h10000, 17'h0FFFF, 17'h1FFFF, 16'hFFFF, 16'hFFFF, CMD_NONE, 1'b1);
    send_tick(0, 0, 17'sd32768, 16'd32768, 0, CMD_NONE, 1'b0);
    send_tick(0, 0, -17'sd32768, 16'd100, 1, CMD_NONE, 1'b1);
    send_tick(17'sd1000, 17'sd2000, 17'sd3000, 16'd20000, 16'hFFFF, CMD_NONE, 1'b0);
    send_tick(0, 0, 0, 16'd20000, 16'hFFFF, CMD_NONE, 1'b0);
    send_tick(0, 0, 0, 16'd20000, 16'hFFFF, CMD_NONE, 1'b1);
    send_tick(17'sd500, 0, 0, 16'd20000, 100, qmm_pkg::CMD_DISARM, 1'b1);
    send_tick(0, 0, 0, 0, 100, CMD_NONE, 1'b1);
    wait_drained();
  endtask

  task automatic test_short_ramps();
    set_regs(qmm_pkg::SPIN_ARM_RST, qmm_pkg::SPIN_MIN_RST, qmm_pkg::SPIN_MAX_RST,
             20000, 15000, 60000);
    fly_random(400, 85, 3000);
    wait_drained();
  endtask

  task automatic test_extreme_limits();
    set_regs(0, 0, 32768, 0, 0, 24'hFFFFFF);
    fly_random(400, 80, 3000);
    wait_drained();
  endtask

  task automatic test_disordered_limits();
    // Spin limits out of order; long up ramp so small steps truncate to nothing.
    set_regs(16'hFFFF, 100, 50, 24'hFFFFFF, 1, 3000);
    fly_random(100, 40, 800);
    wait_drained();
    set_regs(20000, 100, 50, 24'hFFFFFF, 5000, 24'hFFFFFF);
    fly_random(80, 95, 1500);
    wait_drained();
    // Lowering the timeout clips the running idle timer.
    set_regs(20000, 100, 50, 24'hFFFFFF, 5000, 700);
    fly_random(20, 30, 300);
    wait_drained();
  endtask

  task automatic test_mid_settings();
    set_regs(1000, 8000, 20000, 100000, 70000, 200000);
    fly_random(250, 75, 20000);
    wait_drained();
  endtask

  always @(posedge clk) begin
    motor_cmd_t want_cmd;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_cmds.size() == 0) begin
        $error("unexpected result with nothing outstanding");
        errors++;
      end else begin
        want_cmd = pending_cmds.pop_front();
        if (out_thrust_front_right !== want_cmd.thrust[0]) begin
          $error("thrust_front_right exp %0d got %0d", want_cmd.thrust[0],
                 out_thrust_front_right);
          errors++;
        end
        if (out_thrust_rear_left !== want_cmd.thrust[1]) begin
          $error("thrust_rear_left exp %0d got %0d", want_cmd.thrust[1], out_thrust_rear_left);
          errors++;
        end
        if (out_thrust_front_left !== want_cmd.thrust[2]) begin
          $error("thrust_front_left exp %0d got %0d", want_cmd.thrust[2],
                 out_thrust_front_left);
          errors++;
        end
        if (out_thrust_rear_right !== want_cmd.thrust[3]) begin
          $error("thrust_rear_right exp %0d got %0d", want_cmd.thrust[3],
                 out_thrust_rear_right);
          errors++;
        end
        if (out_spool_phase !== want_cmd.phase) begin
          $error("spool_phase exp %0d got %0d", want_cmd.phase, out_spool_phase);
          errors++;
        end
        if (out_limit_roll_pitch !== want_cmd.lim[0]) begin
          $error("limit_roll_pitch exp %0d got %0d", want_cmd.lim[0], out_limit_roll_pitch);
          errors++;
        end
        if (out_limit_throttle_upper !== want_cmd.lim[1]) begin
          $error("limit_throttle_upper exp %0d got %0d", want_cmd.lim[1],
                 out_limit_throttle_upper);
          errors++;
        end
        if (out_limit_throttle_lower !== want_cmd.lim[2]) begin
          $error("limit_throttle_lower exp %0d got %0d", want_cmd.lim[2],
                 out_limit_throttle_lower);
          errors++;
        end
        if (out_limit_yaw !== want_cmd.lim[3]) begin
          $error("limit_yaw exp %0d got %0d", want_cmd.lim[3], out_limit_yaw);
          errors++;
        end
      end
    end
  end

  initial begin
    reset_prediction();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    in_gap_pct = 29;
    out_stall_pct = 58;
    test_directed_extremes();
    test_short_ramps();
    in_gap_pct = 58;
    out_stall_pct = 29;
    test_extreme_limits();
    test_disordered_limits();
    in_gap_pct = 0;
    out_stall_pct = 0;
    test_mid_settings();
    $display("Covered %0d control ticks and %0d checked motor commands over seven register sets.",
             ticks_sent, results_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("FAILURE");
    $finish;
  end

endmodule
